### hdl/gnss_fix_quality_qualifier_macros.svh
// Assertion helpers for the fix quality qualifier.
// All checks are clocked by clk_i and held off while rst_ni is low.
`ifndef GNSS_FIX_QUALITY_QUALIFIER_MACROS_SVH
`define GNSS_FIX_QUALITY_QUALIFIER_MACROS_SVH

// Same-cycle implication
`define GFQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gfq assertion failed");

// Next-cycle implication
`define GFQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gfq assertion failed");

`endif

### hdl/gfq_pkg.sv
package gfq_pkg;

  // Quality word layout
  localparam int unsigned QW_W      = 10;
  localparam int unsigned QB_FIX    = 0;
  localparam int unsigned QB_COUNT  = 1;
  localparam int unsigned QB_DOP    = 2;
  localparam int unsigned QB_ACC    = 3;
  localparam int unsigned QB_CACC   = 4;
  localparam int unsigned QB_SLOPE  = 5;
  localparam int unsigned QB_STAB   = 6;
  localparam int unsigned QB_INCR   = 7;
  localparam int unsigned QB_DIST   = 8;
  localparam int unsigned QB_HEIGHT = 9;

  localparam logic [QW_W-1:0] MASK_ACCEPTED = 10'h20F;
  localparam logic [QW_W-1:0] MASK_EASY     = 10'h007;
  localparam logic [QW_W-1:0] MASK_WARN     = 10'h3FF;

  // Fixed thresholds
  localparam logic signed [15:0] AVG_SLOPE_LIMIT  = 16'sd5;
  localparam logic signed [15:0] HEIGHT_VAR_LIMIT = 16'sd15;
  localparam logic signed [15:0] ACC_VAR_LIMIT    = 16'sd15;
  localparam logic        [15:0] HACC_UPPER_LIMIT = 16'd250;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SATS    = 3'd0,
    CFG_DOP_LIMIT   = 3'd1,
    CFG_HACC_LIMIT  = 3'd2,
    CFG_CACC_LIMIT  = 3'd3,
    CFG_TIMEOUT     = 3'd4,
    CFG_SLOPE_LIMIT = 3'd5,
    CFG_INCR_LIMIT  = 3'd6,
    CFG_WARN_DIST   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_FIX  = 2'd0,
    MODE_DIST = 2'd1,
    MODE_TICK = 2'd2
  } mode_e;

  typedef struct packed {
    logic        [7:0]  min_satellites;
    logic        [15:0] dop_limit;
    logic        [15:0] hacc_limit;
    logic        [15:0] course_acc_limit;
    logic        [15:0] timeout_ticks;
    logic signed [15:0] slope_limit;
    logic        [7:0]  increase_count_limit;
    logic signed [15:0] warn_min_distance;
  } cfg_t;

  typedef struct packed {
    logic        [1:0]  mode;
    logic               fix_valid;
    logic        [7:0]  satellites;
    logic        [15:0] hdop;
    logic        [15:0] hacc_dm;
    logic        [15:0] course_acc;
    logic signed [15:0] avg_fence_step;
    logic signed [15:0] fence_step;
    logic        [7:0]  increase_count;
    logic signed [15:0] height_var;
    logic signed [15:0] acc_var;
    logic signed [15:0] mean_distance;
  } item_t;

  typedef struct packed {
    logic [QW_W-1:0] quality;
    logic [QW_W-1:0] timed;
    logic [15:0]     ticks_left;
    logic            running;
  } state_t;

  typedef struct packed {
    logic [QW_W-1:0] quality_bits;
    logic            has_fix;
    logic            accepted_fix;
    logic            easy_fix;
    logic            warn_fix;
    logic            timeout_event;
  } result_t;

endpackage

### hdl/gnss_fix_quality_qualifier.sv
// A beat accepted at the input goes through the input register, then the
// result register, before it shows on the output. Throughput: one beat per
// cycle while out_ready_i is high; the state update sets the rate.
// Reset (rst_ni low, asynchronous): quality word, timeout copy and timer clear,
// both pipeline registers empty, configuration back to its default values.
`include "gnss_fix_quality_qualifier_macros.svh"

module gnss_fix_quality_qualifier
  import gfq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            mode_i,
  input  logic                  fix_valid_i,
  input  logic [7:0]            satellites_i,
  input  logic [15:0]           hdop_i,
  input  logic [15:0]           hacc_dm_i,
  input  logic [15:0]           course_acc_i,
  input  logic signed [15:0]    avg_fence_step_i,
  input  logic signed [15:0]    fence_step_i,
  input  logic [7:0]            increase_count_i,
  input  logic signed [15:0]    height_var_i,
  input  logic signed [15:0]    acc_var_i,
  input  logic signed [15:0]    mean_distance_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [QW_W-1:0]       quality_bits_o,
  output logic                  has_fix_o,
  output logic                  accepted_fix_o,
  output logic                  easy_fix_o,
  output logic                  warn_fix_o,
  output logic                  timeout_event_o
);

  cfg_t    cfg;
  item_t   item_d, item_q;
  logic    in_vld_d, in_vld_q;
  logic    out_vld_d, out_vld_q;
  state_t  state_d, state_q, state_nxt;
  result_t res_d, res_q, res_nxt;
  logic    adv;
  logic    in_take;

  gfq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gfq_qualify u_qualify (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_nxt),
    .result_o (res_nxt)
  );

  // Handshake: the staged beat moves on when the result slot is free or draining
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_take    = in_valid_i && in_ready_o;

  // Input stage
  always_comb begin
    item_d.mode           = mode_i;
    item_d.fix_valid      = fix_valid_i;
    item_d.satellites     = satellites_i;
    item_d.hdop           = hdop_i;
    item_d.hacc_dm        = hacc_dm_i;
    item_d.course_acc     = course_acc_i;
    item_d.avg_fence_step = avg_fence_step_i;
    item_d.fence_step     = fence_step_i;
    item_d.increase_count = increase_count_i;
    item_d.height_var     = height_var_i;
    item_d.acc_var        = acc_var_i;
    item_d.mean_distance  = mean_distance_i;
  end

  always_comb begin
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  // State and result stage
  assign state_d = adv ? state_nxt : state_q;
  assign res_d   = adv ? res_nxt : res_q;

  always_comb begin
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    res_q <= res_d;
  end

  assign out_valid_o     = out_vld_q;
  assign quality_bits_o  = res_q.quality_bits;
  assign has_fix_o       = res_q.has_fix;
  assign accepted_fix_o  = res_q.accepted_fix;
  assign easy_fix_o      = res_q.easy_fix;
  assign warn_fix_o      = res_q.warn_fix;
  assign timeout_event_o = res_q.timeout_event;

  // Checks
  `GFQ_ASSERT_IMP(a_idle_timer_zero, !state_q.running, state_q.ticks_left == 16'd0)
  `GFQ_ASSERT_IMP(a_running_copy_match, state_q.running, state_q.timed == state_q.quality)
  `GFQ_ASSERT_IMP(a_expiry_clears_easy, out_vld_q && res_q.timeout_event, !res_q.easy_fix)
  `GFQ_ASSERT_IMP(a_warn_implies_accept, out_vld_q && res_q.warn_fix,
                  res_q.accepted_fix && res_q.has_fix)

endmodule

### hdl/gfq_cfg_regs.sv
module gfq_cfg_regs
  import gfq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_d, cfg_q;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_SATS:    cfg_d.min_satellites       = cfg_wdata_i[7:0];
        CFG_DOP_LIMIT:   cfg_d.dop_limit            = cfg_wdata_i;
        CFG_HACC_LIMIT:  cfg_d.hacc_limit           = cfg_wdata_i;
        CFG_CACC_LIMIT:  cfg_d.course_acc_limit     = cfg_wdata_i;
        CFG_TIMEOUT:     cfg_d.timeout_ticks        = cfg_wdata_i;
        CFG_SLOPE_LIMIT: cfg_d.slope_limit          = $signed(cfg_wdata_i);
        CFG_INCR_LIMIT:  cfg_d.increase_count_limit = cfg_wdata_i[7:0];
        CFG_WARN_DIST:   cfg_d.warn_min_distance    = $signed(cfg_wdata_i);
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_satellites       <= 8'd4;
      cfg_q.dop_limit            <= 16'd500;
      cfg_q.hacc_limit           <= 16'd100;
      cfg_q.course_acc_limit     <= 16'd1000;
      cfg_q.timeout_ticks        <= 16'd1000;
      cfg_q.slope_limit          <= 16'sd10;
      cfg_q.increase_count_limit <= 8'd3;
      cfg_q.warn_min_distance    <= 16'sd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/gfq_qualify.sv
module gfq_qualify
  import gfq_pkg::*;
(
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  state_t  state_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [QW_W-1:0] fix_word;
  logic [QW_W-1:0] dist_word;
  logic            expire;

  // Fresh word from a fix report
  always_comb begin
    fix_word            = '0;
    fix_word[QB_HEIGHT] = 1'b1;
    fix_word[QB_FIX]    = item_i.fix_valid;
    fix_word[QB_COUNT]  = (item_i.satellites >= cfg_i.min_satellites);
    fix_word[QB_DOP]    = (item_i.hdop < cfg_i.dop_limit);
    fix_word[QB_ACC]    = (item_i.hacc_dm < cfg_i.hacc_limit);
    fix_word[QB_CACC]   = (item_i.course_acc < cfg_i.course_acc_limit);
  end

  // Bits a distance report ORs into the current word
  always_comb begin
    dist_word = state_i.quality;
    if ($signed(item_i.avg_fence_step) >= AVG_SLOPE_LIMIT) begin
      dist_word[QB_SLOPE] = 1'b1;
      dist_word[QB_INCR]  = 1'b1;
    end else begin
      if ($signed(item_i.fence_step) >= $signed(cfg_i.slope_limit)) begin
        dist_word[QB_SLOPE] = 1'b1;
      end
      if (item_i.increase_count >= cfg_i.increase_count_limit) begin
        dist_word[QB_INCR] = 1'b1;
      end
    end
    if (($signed(item_i.height_var) < HEIGHT_VAR_LIMIT) &&
        ($signed(item_i.acc_var) < ACC_VAR_LIMIT)) begin
      dist_word[QB_STAB] = 1'b1;
    end
    if ((item_i.hacc_dm <= HACC_UPPER_LIMIT) &&
        ($signed(item_i.mean_distance) > $signed(cfg_i.warn_min_distance))) begin
      dist_word[QB_DIST] = 1'b1;
    end
  end

  // Timeout reaches its end on this tick (zero load counts as one)
  assign expire = state_i.running && (state_i.ticks_left <= 16'd1);

  // State update per mode
  always_comb begin
    state_o = state_i;
    result_o.timeout_event = 1'b0;
    unique case (mode_e'(item_i.mode))
      MODE_FIX: begin
        state_o.quality    = fix_word;
        state_o.timed      = fix_word;
        state_o.ticks_left = cfg_i.timeout_ticks;
        state_o.running    = 1'b1;
      end
      MODE_DIST: begin
        state_o.quality = dist_word;
        state_o.timed   = dist_word;
      end
      MODE_TICK: begin
        if (expire) begin
          state_o.ticks_left     = '0;
          state_o.running        = 1'b0;
          state_o.timed          = '0;
          result_o.timeout_event = 1'b1;
        end else if (state_i.running) begin
          state_o.ticks_left = state_i.ticks_left - 16'd1;
        end
      end
      default: state_o = state_i;
    endcase

    // Mask tests on the updated words
    result_o.quality_bits = state_o.quality;
    result_o.has_fix      = state_o.quality[QB_FIX];
    result_o.accepted_fix = ((state_o.quality & MASK_ACCEPTED) == MASK_ACCEPTED);
    result_o.easy_fix     = ((state_o.timed & MASK_EASY) == MASK_EASY);
    result_o.warn_fix     = ((state_o.quality & MASK_WARN) == MASK_WARN);
  end

endmodule

### test/tb_gnss_fix_quality_qualifier.sv
module tb_gnss_fix_quality_qualifier;
  import gfq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_BEATS  = 260;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;
  always #2 clk_i = ~clk_i;

  // DUT ports
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            mode_i;
  logic                  fix_valid_i;
  logic [7:0]            satellites_i;
  logic [15:0]           hdop_i;
  logic [15:0]           hacc_dm_i;
  logic [15:0]           course_acc_i;
  logic signed [15:0]    avg_fence_step_i;
  logic signed [15:0]    fence_step_i;
  logic [7:0]            increase_count_i;
  logic signed [15:0]    height_var_i;
  logic signed [15:0]    acc_var_i;
  logic signed [15:0]    mean_distance_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [QW_W-1:0]       quality_bits_o;
  logic                  has_fix_o;
  logic                  accepted_fix_o;
  logic                  easy_fix_o;
  logic                  warn_fix_o;
  logic                  timeout_event_o;

  gnss_fix_quality_qualifier uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .fix_valid_i      (fix_valid_i),
    .satellites_i     (satellites_i),
    .hdop_i           (hdop_i),
    .hacc_dm_i        (hacc_dm_i),
    .course_acc_i     (course_acc_i),
    .avg_fence_step_i (avg_fence_step_i),
    .fence_step_i     (fence_step_i),
    .increase_count_i (increase_count_i),
    .height_var_i     (height_var_i),
    .acc_var_i        (acc_var_i),
    .mean_distance_i  (mean_distance_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .quality_bits_o   (quality_bits_o),
    .has_fix_o        (has_fix_o),
    .accepted_fix_o   (accepted_fix_o),
    .easy_fix_o       (easy_fix_o),
    .warn_fix_o       (warn_fix_o),
    .timeout_event_o  (timeout_event_o)
  );

  // Shared testbench state
  result_t     predicted_quality_q[$];
  int unsigned error_count   = 0;
  int unsigned beats_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned expiry_count  = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_left     = 0;
  bit          tx_gaps       = 1'b0;
  bit          rx_stalls     = 1'b0;
  logic [15:0] rx_pattern    = 16'hA5C3;

  // Qualifier model: thresholds and state
  cfg_t            thresholds;
  logic [QW_W-1:0] qual_word;
  logic [QW_W-1:0] timed_word;
  logic [15:0]     ticks_to_go;
  logic            timer_on;

  function automatic void reset_model();
    thresholds.min_satellites       = 8'd4;
    thresholds.dop_limit            = 16'd500;
    thresholds.hacc_limit           = 16'd100;
    thresholds.course_acc_limit     = 16'd1000;
    thresholds.timeout_ticks        = 16'd1000;
    thresholds.slope_limit          = 16'sd10;
    thresholds.increase_count_limit = 8'd3;
    thresholds.warn_min_distance    = 16'sd0;
    qual_word   = '0;
    timed_word  = '0;
    ticks_to_go = '0;
    timer_on    = 1'b0;
  endfunction

  // Advance the model by one beat and return the result it should produce
  function automatic result_t qualify_beat(item_t it);
    result_t         r;
    logic [QW_W-1:0] w;
    logic            expired;
    expired = 1'b0;
    case (it.mode)
      MODE_FIX: begin
        w = '0;
        w[QB_HEIGHT] = 1'b1;
        w[QB_FIX]    = it.fix_valid;
        w[QB_COUNT]  = it.satellites >= thresholds.min_satellites;
        w[QB_DOP]    = it.hdop < thresholds.dop_limit;
        w[QB_ACC]    = it.hacc_dm < thresholds.hacc_limit;
        w[QB_CACC]   = it.course_acc < thresholds.course_acc_limit;
        qual_word    = w;
        timed_word   = w;
        ticks_to_go  = thresholds.timeout_ticks;
        timer_on     = 1'b1;
      end
      MODE_DIST: begin
        w = qual_word;
        if ($signed(it.avg_fence_step) >= $signed(AVG_SLOPE_LIMIT)) begin
          w[QB_SLOPE] = 1'b1;
          w[QB_INCR]  = 1'b1;
        end else begin
          if ($signed(it.fence_step) >= $signed(thresholds.slope_limit)) w[QB_SLOPE] = 1'b1;
          if (it.increase_count >= thresholds.increase_count_limit) w[QB_INCR] = 1'b1;
        end
        if ($signed(it.height_var) < $signed(HEIGHT_VAR_LIMIT) &&
            $signed(it.acc_var) < $signed(ACC_VAR_LIMIT)) w[QB_STAB] = 1'b1;
        if (it.hacc_dm <= HACC_UPPER_LIMIT &&
            $signed(it.mean_distance) > $signed(thresholds.warn_min_distance)) begin
          w[QB_DIST] = 1'b1;
        end
        qual_word  = w & MASK_WARN;
        timed_word = qual_word;
      end
      MODE_TICK: begin
        // one-shot countdown; a zero load expires on the first tick
        if (timer_on) begin
          if (ticks_to_go <= 16'd1) begin
            ticks_to_go = '0;
            timer_on    = 1'b0;
            timed_word  = '0;
            expired     = 1'b1;
            expiry_count++;
          end else begin
            ticks_to_go--;
          end
        end
      end
      default: ;
    endcase
    r.quality_bits  = qual_word;
    r.has_fix       = qual_word[QB_FIX];
    r.accepted_fix  = (qual_word & MASK_ACCEPTED) == MASK_ACCEPTED;
    r.easy_fix      = (timed_word & MASK_EASY) == MASK_EASY;
    r.warn_fix      = (qual_word & MASK_WARN) == MASK_WARN;
    r.timeout_event = expired;
    return r;
  endfunction

  // Mismatch reporting
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0d] mismatch on %s: got %0h, want %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_quality_q.size() == 0) begin
        report_mismatch("beat with nothing pending", int'(quality_bits_o), 0);
      end else begin
        want = predicted_quality_q.pop_front();
        beats_checked++;
        if (quality_bits_o !== want.quality_bits)
          report_mismatch("quality_bits", int'(quality_bits_o), int'(want.quality_bits));
        if (has_fix_o !== want.has_fix)
          report_mismatch("has_fix", int'(has_fix_o), int'(want.has_fix));
        if (accepted_fix_o !== want.accepted_fix)
          report_mismatch("accepted_fix", int'(accepted_fix_o), int'(want.accepted_fix));
        if (easy_fix_o !== want.easy_fix)
          report_mismatch("easy_fix", int'(easy_fix_o), int'(want.easy_fix));
        if (warn_fix_o !== want.warn_fix)
          report_mismatch("warn_fix", int'(warn_fix_o), int'(want.warn_fix));
        if (timeout_event_o !== want.timeout_event)
          report_mismatch("timeout_event", int'(timeout_event_o),
                          int'(want.timeout_event));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats pending", cycle_count,
               predicted_quality_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: long hold-off, rotating stall pattern, or always ready
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (!rx_stalls) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        if ($urandom_range(0, 63) == 0) rx_pattern = 16'($urandom) | 16'h0101;
      end
    end
  end

  // Register write; the model follows the same truncation
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_MIN_SATS:    thresholds.min_satellites       = val[7:0];
      CFG_DOP_LIMIT:   thresholds.dop_limit            = val;
      CFG_HACC_LIMIT:  thresholds.hacc_limit           = val;
      CFG_CACC_LIMIT:  thresholds.course_acc_limit     = val;
      CFG_TIMEOUT:     thresholds.timeout_ticks        = val;
      CFG_SLOPE_LIMIT: thresholds.slope_limit          = val;
      CFG_INCR_LIMIT:  thresholds.increase_count_limit = val[7:0];
      CFG_WARN_DIST:   thresholds.warn_min_distance    = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(CFG_MIN_SATS,    {8'h00, c.min_satellites});
    write_reg(CFG_DOP_LIMIT,   c.dop_limit);
    write_reg(CFG_HACC_LIMIT,  c.hacc_limit);
    write_reg(CFG_CACC_LIMIT,  c.course_acc_limit);
    write_reg(CFG_TIMEOUT,     c.timeout_ticks);
    write_reg(CFG_SLOPE_LIMIT, c.slope_limit);
    write_reg(CFG_INCR_LIMIT,  {8'h00, c.increase_count_limit});
    write_reg(CFG_WARN_DIST,   c.warn_min_distance);
    settings_used++;
  endtask

  // Send one beat; called and returns just after a falling edge.
  // Valid stays high on return so back-to-back beats need no second assignment.
  task automatic send_beat(item_t it);
    int unsigned gap;
    if (tx_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    mode_i           <= it.mode;
    fix_valid_i      <= it.fix_valid;
    satellites_i     <= it.satellites;
    hdop_i           <= it.hdop;
    hacc_dm_i        <= it.hacc_dm;
    course_acc_i     <= it.course_acc;
    avg_fence_step_i <= it.avg_fence_step;
    fence_step_i     <= it.fence_step;
    increase_count_i <= it.increase_count;
    height_var_i     <= it.height_var;
    acc_var_i        <= it.acc_var;
    mean_distance_i  <= it.mean_distance;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_quality_q.push_back(qualify_beat(it));
    beats_sent++;
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (predicted_quality_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Beat builders
  function automatic item_t random_fields(logic [1:0] m);
    item_t it;
    it.mode           = m;
    it.fix_valid      = 1'($urandom_range(0, 1));
    it.satellites     = 8'($urandom);
    it.hdop           = 16'($urandom);
    it.hacc_dm        = 16'($urandom);
    it.course_acc     = 16'($urandom);
    it.avg_fence_step = 16'($urandom);
    it.fence_step     = 16'($urandom);
    it.increase_count = 8'($urandom);
    it.height_var     = 16'($urandom);
    it.acc_var        = 16'($urandom);
    it.mean_distance  = 16'($urandom);
    return it;
  endfunction

  function automatic item_t fix_report(logic fv, logic [7:0] sats, logic [15:0] hdop,
                                       logic [15:0] hacc, logic [15:0] cacc);
    item_t it;
    it = random_fields(MODE_FIX);
    it.fix_valid  = fv;
    it.satellites = sats;
    it.hdop       = hdop;
    it.hacc_dm    = hacc;
    it.course_acc = cacc;
    return it;
  endfunction

  function automatic item_t dist_report(logic [15:0] avg, logic [15:0] chg, logic [7:0] cnt,
                                        logic [15:0] hd, logic [15:0] ad, logic [15:0] hacc,
                                        logic [15:0] mean);
    item_t it;
    it = random_fields(MODE_DIST);
    it.avg_fence_step = avg;
    it.fence_step     = chg;
    it.increase_count = cnt;
    it.height_var     = hd;
    it.acc_var        = ad;
    it.hacc_dm        = hacc;
    it.mean_distance  = mean;
    return it;
  endfunction

  function automatic logic [15:0] near16(logic [15:0] center);
    logic [15:0] d;
    d = 16'($urandom_range(0, 4));
    return center + d - 16'd2;
  endfunction

  // Random beat: mostly fix/distance/tick traffic, with fields often
  // pulled to within a couple of counts of their thresholds
  function automatic item_t random_report();
    item_t       it;
    logic [15:0] t;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 30)      it = random_fields(MODE_FIX);
    else if (k < 65) it = random_fields(MODE_DIST);
    else if (k < 95) it = random_fields(MODE_TICK);
    else             it = random_fields(MODE_UNUSED);
    if ($urandom_range(0, 1)) begin
      t = near16({8'h00, thresholds.min_satellites});
      it.satellites = t[7:0];
    end
    if ($urandom_range(0, 1)) it.hdop       = near16(thresholds.dop_limit);
    if ($urandom_range(0, 1)) it.course_acc = near16(thresholds.course_acc_limit);
    case ($urandom_range(0, 2))
      0: it.hacc_dm = near16(thresholds.hacc_limit);
      1: it.hacc_dm = near16(HACC_UPPER_LIMIT);
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) it.avg_fence_step = near16(AVG_SLOPE_LIMIT);
    if ($urandom_range(0, 1)) it.fence_step = near16(thresholds.slope_limit);
    if ($urandom_range(0, 1)) begin
      t = near16({8'h00, thresholds.increase_count_limit});
      it.increase_count = t[7:0];
    end
    if ($urandom_range(0, 1)) it.height_var    = near16(HEIGHT_VAR_LIMIT);
    if ($urandom_range(0, 1)) it.acc_var       = near16(ACC_VAR_LIMIT);
    if ($urandom_range(0, 1)) it.mean_distance = near16(thresholds.warn_min_distance);
    return it;
  endfunction

  // Threshold edges and field extremes under the reset configuration
  task automatic test_reset_defaults();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_beat(random_fields(MODE_TICK));          // tick before any fix: no effect
    send_beat(random_fields(MODE_UNUSED));
    send_beat(fix_report(1'b1, 8'd4, 16'd499, 16'd99, 16'd999));
    send_beat(fix_report(1'b0, 8'd3, 16'd500, 16'd100, 16'd1000));
    send_beat(fix_report(1'b1, 8'd255, 16'd0, 16'd0, 16'd0));
    send_beat(fix_report(1'b1, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(fix_report(1'b1, 8'd4, 16'd0, 16'd0, 16'd0));
    // average slope forces slope and increase; all four distance bits set
    send_beat(dist_report(16'd5, 16'h8000, 8'd0, 16'd14, 16'd14, 16'd250, 16'd1));
    send_beat(fix_report(1'b1, 8'd4, 16'd499, 16'd99, 16'd999));
    send_beat(dist_report(16'd4, 16'd10, 8'd2, 16'd15, 16'h8000, 16'd251, 16'h7FFF));
    send_beat(dist_report(16'h8000, 16'd9, 8'd3, 16'h8000, 16'd15, 16'd0, 16'd0));
    send_beat(dist_report(16'h7FFF, 16'h7FFF, 8'd255, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                          16'h8000));
    send_beat(random_fields(MODE_UNUSED));
    send_beat(random_fields(MODE_TICK));
    drain();
  endtask

  // Timer expiry, zero load, and a distance report after expiry
  task automatic test_timeout();
    write_reg(CFG_TIMEOUT, 16'd0);
    send_beat(fix_report(1'b1, 8'd9, 16'd1, 16'd1, 16'd1));
    send_beat(random_fields(MODE_TICK));          // zero load expires at once
    send_beat(random_fields(MODE_TICK));          // idle again
    drain();
    write_reg(CFG_TIMEOUT, 16'd3);
    send_beat(fix_report(1'b1, 8'd9, 16'd1, 16'd1, 16'd1));
    send_beat(random_fields(MODE_TICK));
    send_beat(random_fields(MODE_TICK));
    send_beat(dist_report(16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd5));
    send_beat(random_fields(MODE_TICK));          // expires here
    // timer stopped: report still refreshes the timeout copy
    send_beat(dist_report(16'd6, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd5));
    send_beat(random_fields(MODE_TICK));
    drain();
  endtask

  // Random traffic under a run of settings, extremes first
  task automatic test_config_sweep();
    cfg_t c;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          c.min_satellites = 8'd0;  c.dop_limit = 16'd0;  c.hacc_limit = 16'd0;
          c.course_acc_limit = 16'd0;  c.timeout_ticks = 16'd0;
          c.slope_limit = 16'h8000;  c.increase_count_limit = 8'd0;
          c.warn_min_distance = 16'h8000;
        end
        1: begin
          c.min_satellites = 8'hFF;  c.dop_limit = 16'hFFFF;  c.hacc_limit = 16'hFFFF;
          c.course_acc_limit = 16'hFFFF;  c.timeout_ticks = 16'hFFFF;
          c.slope_limit = 16'h7FFF;  c.increase_count_limit = 8'hFF;
          c.warn_min_distance = 16'h7FFF;
        end
        default: begin
          c.min_satellites       = 8'($urandom);
          c.dop_limit            = 16'($urandom);
          c.hacc_limit           = 16'($urandom);
          c.course_acc_limit     = 16'($urandom);
          c.timeout_ticks        = 16'($urandom_range(1, 12));
          c.slope_limit          = 16'($urandom);
          c.increase_count_limit = 8'($urandom);
          c.warn_min_distance    = 16'($urandom);
        end
      endcase
      apply_config(c);
      tx_gaps   = (ph % 3) != 0;
      rx_stalls = (ph % 2) != 0;
      for (int n = 0; n < PHASE_BEATS; n++) send_beat(random_report());
      drain();
    end
  endtask

  // Receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    hold_left = HOLD_CYCLES;
    for (int n = 0; n < 40; n++) send_beat(random_report());
    drain();
  endtask

  // Stimulus sequence
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_MIN_SATS;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    mode_i           = MODE_FIX;
    fix_valid_i      = 1'b0;
    satellites_i     = '0;
    hdop_i           = '0;
    hacc_dm_i        = '0;
    course_acc_i     = '0;
    avg_fence_step_i = '0;
    fence_step_i     = '0;
    increase_count_i = '0;
    height_var_i     = '0;
    acc_var_i        = '0;
    mean_distance_i  = '0;
    reset_model();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_defaults();
    test_timeout();
    test_config_sweep();
    test_backpressure();

    repeat (8) @(negedge clk_i);
    if (predicted_quality_q.size() != 0)
      report_mismatch("results never delivered", 0, predicted_quality_q.size());
    $display("Ran %0d beats (%0d checked) over %0d full register settings plus edits.",
             beats_sent, beats_checked, settings_used);
    $display("Fix, distance, tick and unused modes; %0d timer expiries; long output hold-off.",
             expiry_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
